// ===== rtl/core/gte_pkg.sv =====
// Shared types and constants for the GF(2^8) table erasure encoder.
// Used by the channel interfaces, the table bank and the top level.
package gte_pkg;

  localparam int unsigned MaxSourcesDefault = 16;
  localparam int unsigned MaxDestsDefault   = 4;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned NibbleW   = 4;
  localparam int unsigned TableAddrW = 11;
  localparam int unsigned DestIdxW  = 2;
  localparam int unsigned HalfSize  = 16;
  localparam int unsigned PairSize  = 32;
  localparam int unsigned HalfBit   = 4;

  localparam int unsigned SrcCountW = 5;
  localparam int unsigned DstCountW = 3;
  localparam int unsigned BlockLenW = 16;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic {
    OP_TABLE_WRITE = 1'b0,
    OP_SOURCE_DATA = 1'b1
  } op_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_SOURCE_COUNT = 2'd0,
    REG_DEST_COUNT   = 2'd1,
    REG_BLOCK_LENGTH = 2'd2
  } reg_idx_t;

endpackage

// ===== rtl/core/gte_if.sv =====
// Valid/ready channels of the erasure encoder: requests in, parity bytes out.
// Depends on gte_pkg for field widths.
interface gte_item_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [gte_pkg::TableAddrW-1:0]    table_address;
  logic [gte_pkg::ByteW-1:0]         table_value;
  logic [gte_pkg::ByteW-1:0]         source_byte;

  modport source (output valid, operation, table_address, table_value, source_byte,
                  input ready);
  modport sink   (input valid, operation, table_address, table_value, source_byte,
                  output ready);
endinterface

interface gte_result_if;
  logic                              valid;
  logic                              ready;
  logic [gte_pkg::DestIdxW-1:0]      dest_index;
  logic [gte_pkg::ByteW-1:0]         parity_byte;
  logic                              last_of_run;
  logic                              block_end;

  modport source (output valid, dest_index, parity_byte, last_of_run, block_end,
                  input ready);
  modport sink   (input valid, dest_index, parity_byte, last_of_run, block_end,
                  output ready);
endinterface

// ===== rtl/core/gf256_table_erasure_encoder.sv =====
// Top level of the GF(2^8) split-nibble erasure encoder.
// Depends on gte_pkg, gte_if (channels) and gte_bank (table banks).
//
//   channel  dir  handshake      payload
//   item     in   valid/ready    operation, table_address, table_value, source_byte
//   result   out  valid/ready    dest_index, parity_byte, last_of_run, block_end
//   cfg      in   cfg_write      cfg_index, cfg_data (no read-back)
//
// One request per cycle unless stalled; source bytes pass the registered banks into the
// accumulators. A position emits the clamped dest_count results from a result buffer, one
// per cycle while result.ready is high; with source_count >= dest_count and result.ready
// held, one request per cycle is sustained. The buffer holds one position; a completed
// position waits in the lookup stage until the buffer drains, which stalls the item channel.
// Reset is synchronous; the table contents survive reset and need no clearing pass.
module gf256_table_erasure_encoder #(
  parameter int unsigned MAX_SOURCES = gte_pkg::MaxSourcesDefault,
  parameter int unsigned MAX_DESTS   = gte_pkg::MaxDestsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  gte_item_if.sink                        item,
  gte_result_if.source                    result,
  input  logic                            cfg_write,
  input  logic [gte_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [gte_pkg::CfgDataW-1:0]    cfg_data
);

  localparam int unsigned TableDepth = MAX_DESTS * MAX_SOURCES * gte_pkg::PairSize;
  localparam int unsigned BankDepth  = MAX_DESTS * MAX_SOURCES * gte_pkg::HalfSize;
  localparam int unsigned PW  = (MAX_DESTS * MAX_SOURCES > 1) ?
                                $clog2(MAX_DESTS * MAX_SOURCES) : 1;
  localparam int unsigned LAW = PW + gte_pkg::NibbleW;
  localparam int unsigned SW  = $clog2(MAX_SOURCES + 1);
  localparam int unsigned DW  = $clog2(MAX_DESTS + 1);
  localparam int unsigned SPW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int unsigned IW  = (MAX_DESTS > 1) ? $clog2(MAX_DESTS) : 1;
  localparam int unsigned BW  = gte_pkg::ByteW;

  logic [gte_pkg::SrcCountW-1:0] source_count;
  logic [gte_pkg::DstCountW-1:0] dest_count;
  logic [gte_pkg::BlockLenW-1:0] block_length;

  logic [SW-1:0]  srcs_c;
  logic [DW-1:0]  dsts_c;
  logic [gte_pkg::BlockLenW-1:0] blen_c;

  logic [SPW-1:0] src_pos;
  logic [SPW-1:0] src_pos_next;
  logic [gte_pkg::BlockLenW-1:0] byte_pos;
  logic [gte_pkg::BlockLenW-1:0] byte_pos_next;
  logic [SPW-1:0] cur_src;
  logic           src_last;
  logic           pos_end;

  logic           item_fire;
  logic           data_fire;
  logic           wr_ok;
  logic [LAW-1:0] wr_local;

  logic           s1_valid;
  logic           s1_last;
  logic           s1_end;
  logic           s1_adv;

  logic [PW-1:0]  pair   [MAX_DESTS];
  logic [BW-1:0]  lo_q   [MAX_DESTS];
  logic [BW-1:0]  hi_q   [MAX_DESTS];
  logic [BW-1:0]  prod   [MAX_DESTS];
  logic [BW-1:0]  acc    [MAX_DESTS];

  logic [BW-1:0]  buf_bytes [MAX_DESTS];
  logic           buf_valid;
  logic           buf_end;
  logic [IW-1:0]  buf_idx;
  logic           idx_last;
  logic           result_fire;
  logic           buf_free;
  logic           buf_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_count <= gte_pkg::SrcCountW'(1);
      dest_count   <= gte_pkg::DstCountW'(1);
      block_length <= gte_pkg::BlockLenW'(1);
    end else if (cfg_write) begin
      unique case (gte_pkg::reg_idx_t'(cfg_index))
        gte_pkg::REG_SOURCE_COUNT: source_count <= cfg_data[gte_pkg::SrcCountW-1:0];
        gte_pkg::REG_DEST_COUNT:   dest_count   <= cfg_data[gte_pkg::DstCountW-1:0];
        gte_pkg::REG_BLOCK_LENGTH: block_length <= cfg_data[gte_pkg::BlockLenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (source_count == '0) begin
      srcs_c = SW'(1);
    end else if (32'(source_count) > MAX_SOURCES) begin
      srcs_c = SW'(MAX_SOURCES);
    end else begin
      srcs_c = SW'(source_count);
    end
    if (dest_count == '0) begin
      dsts_c = DW'(1);
    end else if (32'(dest_count) > MAX_DESTS) begin
      dsts_c = DW'(MAX_DESTS);
    end else begin
      dsts_c = DW'(dest_count);
    end
    blen_c = (block_length == '0) ? gte_pkg::BlockLenW'(1) : block_length;
  end

  // Stage 0: counters and table addressing
  assign item_fire = item.valid && item.ready;
  assign data_fire = item_fire && (item.operation == gte_pkg::OP_SOURCE_DATA);
  assign wr_ok     = item_fire && (item.operation == gte_pkg::OP_TABLE_WRITE) &&
                     (32'(item.table_address) < TableDepth);
  assign wr_local  = LAW'({item.table_address[gte_pkg::TableAddrW-1:gte_pkg::HalfBit+1],
                           item.table_address[gte_pkg::NibbleW-1:0]});

  assign src_last = (32'(src_pos) + 32'd1) >= 32'(srcs_c);
  assign cur_src  = src_last ? SPW'(srcs_c - SW'(1)) : src_pos;
  assign pos_end  = (32'(byte_pos) + 32'd1) >= 32'(blen_c);

  always_comb begin
    src_pos_next  = src_pos;
    byte_pos_next = byte_pos;
    if (data_fire) begin
      if (src_last) begin
        src_pos_next  = '0;
        byte_pos_next = pos_end ? '0 : byte_pos + gte_pkg::BlockLenW'(1);
      end else begin
        src_pos_next = src_pos + SPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_pos  <= '0;
      byte_pos <= '0;
    end else begin
      src_pos  <= src_pos_next;
      byte_pos <= byte_pos_next;
    end
  end

  for (genvar l = 0; l < MAX_DESTS; l++) begin : g_lane
    assign pair[l] = PW'(32'(l) * 32'(srcs_c) + 32'(cur_src));

    gte_bank #(.DEPTH(BankDepth), .AW(LAW)) u_lo (
      .clk   (clk),
      .we    (wr_ok && !item.table_address[gte_pkg::HalfBit]),
      .waddr (wr_local),
      .wdata (item.table_value),
      .re    (data_fire),
      .raddr ({pair[l], item.source_byte[gte_pkg::NibbleW-1:0]}),
      .rdata (lo_q[l])
    );

    gte_bank #(.DEPTH(BankDepth), .AW(LAW)) u_hi (
      .clk   (clk),
      .we    (wr_ok && item.table_address[gte_pkg::HalfBit]),
      .waddr (wr_local),
      .wdata (item.table_value),
      .re    (data_fire),
      .raddr ({pair[l], item.source_byte[BW-1:gte_pkg::NibbleW]}),
      .rdata (hi_q[l])
    );

    assign prod[l] = lo_q[l] ^ hi_q[l];
  end

  // Stage 1: accumulate, hand completed positions to the result buffer
  assign result_fire = result.valid && result.ready;
  assign idx_last    = (buf_idx == IW'(dsts_c - DW'(1)));
  assign buf_free    = !buf_valid || (result_fire && idx_last);
  assign s1_adv      = s1_valid && (!s1_last || buf_free);
  assign buf_load    = s1_adv && s1_last;
  assign item.ready  = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_fire) begin
      s1_valid <= data_fire;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_fire) begin
      s1_last <= src_last;
      s1_end  <= pos_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < MAX_DESTS; l++) begin
        acc[l] <= '0;
      end
    end else if (s1_adv) begin
      for (int l = 0; l < MAX_DESTS; l++) begin
        if (32'(l) < 32'(dsts_c)) begin
          acc[l] <= s1_last ? '0 : (acc[l] ^ prod[l]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (buf_load) begin
      for (int l = 0; l < MAX_DESTS; l++) begin
        buf_bytes[l] <= acc[l] ^ prod[l];
      end
      buf_end <= s1_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      buf_idx   <= '0;
    end else if (buf_load) begin
      buf_valid <= 1'b1;
      buf_idx   <= '0;
    end else if (result_fire) begin
      if (idx_last) begin
        buf_valid <= 1'b0;
      end else begin
        buf_idx <= buf_idx + IW'(1);
      end
    end
  end

  assign result.valid       = buf_valid;
  assign result.dest_index  = gte_pkg::DestIdxW'(buf_idx);
  assign result.parity_byte = buf_bytes[buf_idx];
  assign result.last_of_run = idx_last;
  assign result.block_end   = buf_end;

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (s1_valid && s1_last && buf_valid))
    else $error("item channel stalled without a pending completed position");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    buf_valid |-> (32'(buf_idx) < 32'(dsts_c)))
    else $error("result index beyond active destinations");

  a_buffer_drains: assert property (@(posedge clk) disable iff (rst)
    (result_fire && idx_last && !buf_load) |=> !buf_valid)
    else $error("result buffer not released after final destination");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    buf_load |=> (acc[0] == '0))
    else $error("accumulator not cleared after position completed");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_end) && $stable(prod[0])))
    else $error("stalled lookup stage lost its contents");

endmodule

// ===== rtl/core/gte_bank.sv =====
// One product-table bank: one write port, one registered read port.
// Depends on gte_pkg for the byte width.
module gte_bank #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [gte_pkg::ByteW-1:0]  wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [gte_pkg::ByteW-1:0]  rdata
);

  logic [gte_pkg::ByteW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for gf256_table_erasure_encoder: writes table entries before use,
// runs directed and random source streams and checks parity bytes against an
// in-bench model. Depends on gte_pkg, gte_if and the encoder RTL.
module tb;

  localparam int unsigned NSrcMax    = gte_pkg::MaxSourcesDefault;
  localparam int unsigned NDstMax    = gte_pkg::MaxDestsDefault;
  localparam int unsigned TableDepth = NSrcMax * NDstMax * gte_pkg::PairSize;
  localparam int unsigned DrainSlack = 12;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [gte_pkg::CfgIndexW-1:0] RegSpare = 2'd3;

  typedef struct {
    gte_pkg::op_t                   op;
    logic [gte_pkg::TableAddrW-1:0] addr;
    logic [gte_pkg::ByteW-1:0]      value;
    logic [gte_pkg::ByteW-1:0]      data;
    bit                             drain;
  } request_t;

  typedef struct {
    logic [gte_pkg::DestIdxW-1:0] dest_index;
    logic [gte_pkg::ByteW-1:0]    parity_byte;
    logic                         last_of_run;
    logic                         block_end;
  } parity_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [gte_pkg::CfgIndexW-1:0] cfg_index;
  logic [gte_pkg::CfgDataW-1:0]  cfg_data;

  gte_item_if   item_ch ();
  gte_result_if result_ch ();

  gf256_table_erasure_encoder #(
    .MAX_SOURCES(NSrcMax),
    .MAX_DESTS  (NDstMax)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (result_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  request_t pending[$];
  parity_t  parity_due[$];
  request_t on_wire;
  bit       item_taken;
  bit       gaps_on;
  bit       stall_on;
  int unsigned send_wait;
  int unsigned stall_left;
  int unsigned errors;
  int unsigned cycle_count;

  logic [gte_pkg::ByteW-1:0]     gf_products [TableDepth];
  logic [gte_pkg::ByteW-1:0]     acc_parity [NDstMax];
  logic [gte_pkg::SrcCountW-1:0] n_sources_reg;
  logic [gte_pkg::DstCountW-1:0] n_dests_reg;
  logic [gte_pkg::BlockLenW-1:0] block_len_reg;
  int unsigned                   src_slot;
  int unsigned                   pos_in_block;

  bit          tbl_set [TableDepth];
  int unsigned gen_slot;

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic request_t make_req(gte_pkg::op_t op, int unsigned addr,
                                        int unsigned value, int unsigned data, bit drain);
    request_t r;
    r.op    = op;
    r.addr  = gte_pkg::TableAddrW'(addr);
    r.value = gte_pkg::ByteW'(value);
    r.data  = gte_pkg::ByteW'(data);
    r.drain = drain;
    return r;
  endfunction

  function automatic void push_write(int unsigned addr, int unsigned value, bit drain);
    pending.push_back(make_req(gte_pkg::OP_TABLE_WRITE, addr, value, 0, drain));
    if (addr < TableDepth)
      tbl_set[addr] = 1'b1;
  endfunction

  // write any entry the request will read that is not yet set, before sending it
  function automatic void push_data(logic [gte_pkg::ByteW-1:0] data, bit drain);
    int unsigned srcs, dsts, cur, base, lo_a, hi_a;
    srcs = clamp_cfg(n_sources_reg, NSrcMax);
    dsts = clamp_cfg(n_dests_reg, NDstMax);
    cur  = (gen_slot >= srcs - 1) ? srcs - 1 : gen_slot;
    for (int unsigned d = 0; d < dsts; d++) begin
      base = (d * srcs + cur) * gte_pkg::PairSize;
      lo_a = (base + data[gte_pkg::NibbleW-1:0]) % TableDepth;
      hi_a = (base + gte_pkg::HalfSize + data[gte_pkg::ByteW-1:gte_pkg::NibbleW]) % TableDepth;
      if (!tbl_set[lo_a])
        push_write(lo_a, $urandom_range(0, 255), 1'b0);
      if (!tbl_set[hi_a])
        push_write(hi_a, $urandom_range(0, 255), 1'b0);
    end
    pending.push_back(make_req(gte_pkg::OP_SOURCE_DATA, $urandom_range(0, TableDepth - 1),
                               $urandom_range(0, 255), data, drain));
    gen_slot = (gen_slot + 1 < srcs) ? gen_slot + 1 : 0;
  endfunction

  function automatic logic [gte_pkg::ByteW-1:0] pick_byte();
    logic [gte_pkg::NibbleW-1:0] lo, hi;
    lo = ($urandom_range(0, 1) != 0) ? 4'h3 : 4'hC;
    hi = ($urandom_range(0, 1) != 0) ? 4'h5 : 4'hA;
    return {hi, lo};
  endfunction

  function automatic void predict_parity(request_t r);
    int unsigned srcs, dsts, blen, cur, base;
    bit last_pos;
    parity_t p;
    srcs = clamp_cfg(n_sources_reg, NSrcMax);
    dsts = clamp_cfg(n_dests_reg, NDstMax);
    blen = (block_len_reg == 0) ? 1 : block_len_reg;
    if (r.op == gte_pkg::OP_TABLE_WRITE) begin
      gf_products[r.addr] = r.value;
      return;
    end
    cur = (src_slot >= srcs - 1) ? srcs - 1 : src_slot;
    for (int unsigned d = 0; d < dsts; d++) begin
      base = (d * srcs + cur) * gte_pkg::PairSize;
      acc_parity[d] ^=
        gf_products[(base + r.data[gte_pkg::NibbleW-1:0]) % TableDepth] ^
        gf_products[(base + gte_pkg::HalfSize + r.data[gte_pkg::ByteW-1:gte_pkg::NibbleW])
                    % TableDepth];
    end
    if (src_slot + 1 < srcs) begin
      src_slot++;
      return;
    end
    src_slot = 0;
    last_pos = (pos_in_block + 1 >= blen);
    for (int unsigned d = 0; d < dsts; d++) begin
      p.dest_index  = gte_pkg::DestIdxW'(d);
      p.parity_byte = acc_parity[d];
      p.last_of_run = (d == dsts - 1);
      p.block_end   = last_pos;
      parity_due.push_back(p);
      acc_parity[d] = '0;
    end
    pos_in_block = last_pos ? 0 : pos_in_block + 1;
  endfunction

  task automatic set_reg(logic [gte_pkg::CfgIndexW-1:0] idx,
                         logic [gte_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      gte_pkg::REG_SOURCE_COUNT: n_sources_reg = val[gte_pkg::SrcCountW-1:0];
      gte_pkg::REG_DEST_COUNT:   n_dests_reg   = val[gte_pkg::DstCountW-1:0];
      gte_pkg::REG_BLOCK_LENGTH: block_len_reg = val[gte_pkg::BlockLenW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_quiet();
    @(posedge clk);
    while (pending.size() != 0 || item_ch.valid || parity_due.size() != 0)
      @(posedge clk);
    repeat (DrainSlack) @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    request_t nxt;
    if (rst) begin
      item_ch.valid <= 1'b0;
      send_wait = 0;
    end else if (!item_ch.valid || item_taken) begin
      if (send_wait > 0) begin
        send_wait--;
        item_ch.valid <= 1'b0;
      end else if (pending.size() == 0 || (pending[0].drain && parity_due.size() != 0)) begin
        item_ch.valid <= 1'b0;
      end else begin
        nxt = pending.pop_front();
        on_wire = nxt;
        item_ch.valid         <= 1'b1;
        item_ch.operation     <= nxt.op;
        item_ch.table_address <= nxt.addr;
        item_ch.table_value   <= nxt.value;
        item_ch.source_byte   <= nxt.data;
        send_wait = gaps_on ? idle_span() : 0;
      end
    end
  end

  always @(posedge clk) begin
    item_taken <= !rst && item_ch.valid && item_ch.ready;
    if (!rst && item_ch.valid && item_ch.ready)
      predict_parity(on_wire);
  end

  // result sink: random backpressure while stall_on is set
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      result_ch.ready <= 1'b1;
      stall_left = stall_on ? idle_span() : 0;
    end
  end

  // parity monitor
  always @(posedge clk) begin
    parity_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (parity_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected parity byte: dest %0d byte %02h last %0b end %0b",
                   result_ch.dest_index, result_ch.parity_byte,
                   result_ch.last_of_run, result_ch.block_end);
      end else begin
        want = parity_due.pop_front();
        if (result_ch.dest_index !== want.dest_index ||
            result_ch.parity_byte !== want.parity_byte ||
            result_ch.last_of_run !== want.last_of_run ||
            result_ch.block_end !== want.block_end) begin
          errors++;
          if (errors <= 10)
            $display({"parity mismatch: expected dest %0d byte %02h last %0b end %0b,",
                      " got dest %0d byte %02h last %0b end %0b"},
                     want.dest_index, want.parity_byte, want.last_of_run, want.block_end,
                     result_ch.dest_index, result_ch.parity_byte,
                     result_ch.last_of_run, result_ch.block_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [gte_pkg::CfgDataW-1:0] fix_src [6];
    logic [gte_pkg::CfgDataW-1:0] fix_dst [6];
    logic [gte_pkg::CfgDataW-1:0] fix_len [6];
    logic [gte_pkg::CfgDataW-1:0] v_src, v_dst, v_len;
    int unsigned n_req;
    fix_src = '{16'd3, 16'd1, 16'd0, 16'd31, 16'd16, 16'd2};
    fix_dst = '{16'd4, 16'd1, 16'd0, 16'd1, 16'd4, 16'd7};
    fix_len = '{16'd65535, 16'd1, 16'd0, 16'd2, 16'd5, 16'd1};
    errors      = 0;
    cycle_count = 0;
    item_taken  = 1'b0;
    gaps_on     = 1'b1;
    stall_on    = 1'b1;
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = gte_pkg::REG_SOURCE_COUNT;
    cfg_data    = '0;
    item_ch.valid         = 1'b0;
    item_ch.operation     = gte_pkg::OP_TABLE_WRITE;
    item_ch.table_address = '0;
    item_ch.table_value   = '0;
    item_ch.source_byte   = '0;
    result_ch.ready       = 1'b0;
    n_sources_reg = 1;
    n_dests_reg   = 1;
    block_len_reg = 1;
    src_slot      = 0;
    pos_in_block  = 0;
    gen_slot      = 0;
    for (int i = 0; i < NDstMax; i++) acc_parity[i] = '0;
    for (int i = 0; i < TableDepth; i++) gf_products[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset register values, one source and one parity per position
    push_data(8'h00, 1'b0);
    push_data(8'hFF, 1'b0);
    push_data(8'h0F, 1'b0);
    push_data(8'hF0, 1'b0);
    push_write(15, 8'hA5, 1'b0);
    push_data(8'h0F, 1'b0);
    wait_quiet();

    set_reg(gte_pkg::REG_SOURCE_COUNT, 16'd2);
    set_reg(gte_pkg::REG_DEST_COUNT, 16'd4);
    set_reg(gte_pkg::REG_BLOCK_LENGTH, 16'd2);
    push_data(8'h12, 1'b0);
    push_write(40, 8'h3C, 1'b0);
    push_data(8'h34, 1'b0);
    push_data(8'h80, 1'b0);
    push_data(8'h08, 1'b0);
    push_data(8'hAA, 1'b1);
    push_data(8'h55, 1'b0);
    push_data(8'h33, 1'b0);
    wait_quiet();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 6) begin
        v_src = fix_src[ph];
        v_dst = fix_dst[ph];
        v_len = fix_len[ph];
      end else begin
        v_src = ($urandom_range(0, 3) != 0) ?
                gte_pkg::CfgDataW'($urandom_range(1, 6)) :
                gte_pkg::CfgDataW'($urandom_range(0, 16'hFFFF));
        v_dst = ($urandom_range(0, 1) != 0) ?
                gte_pkg::CfgDataW'($urandom_range(1, 4)) :
                gte_pkg::CfgDataW'($urandom_range(0, 16'hFFFF));
        v_len = ($urandom_range(0, 3) != 0) ?
                gte_pkg::CfgDataW'($urandom_range(0, 6)) :
                gte_pkg::CfgDataW'($urandom_range(0, 16'hFFFF));
      end
      gaps_on  = (ph % 3) != 1;
      stall_on = (ph % 4) != 2;
      set_reg(gte_pkg::REG_SOURCE_COUNT, v_src);
      set_reg(gte_pkg::REG_DEST_COUNT, v_dst);
      set_reg(gte_pkg::REG_BLOCK_LENGTH, v_len);
      if (ph == 4 || $urandom_range(0, 2) == 0)
        set_reg(RegSpare, gte_pkg::CfgDataW'($urandom_range(0, 16'hFFFF)));
      n_req = $urandom_range(6, 12);
      for (int k = 0; k < n_req; k++) begin
        if ($urandom_range(0, 99) < 10)
          push_write($urandom_range(0, TableDepth - 1), $urandom_range(0, 255),
                     $urandom_range(0, 49) == 0);
        push_data(pick_byte(), $urandom_range(0, 49) == 0);
      end
      wait_quiet();
    end

    if (errors == 0 && parity_due.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gte_pkg.sv
rtl/core/gte_if.sv
rtl/core/gte_bank.sv
rtl/core/gf256_table_erasure_encoder.sv
tb/tb.sv
